/* hw/rtl/ddt_pkg.sv */
// Package for the drift-corrected block time pipeline.
// Holds shared constants, register codes, sideband types and the exp2 tables.
// No dependencies.
package ddt_pkg;

    localparam int QBITS   = 30;
    localparam int LATENCY = 42;

    localparam logic [29:0] DRIFT_CLIP = 30'd729822324;

    typedef enum logic [1:0] {
        REG_BLOCK_SPACING  = 2'd0,
        REG_DRIFT_TIMESPAN = 2'd1,
        REG_GENESIS_TIME   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } ddt_side_t;

    function automatic logic [31:0] poly_coef(input logic [1:0] k);
        logic [31:0] c;
        case (k)
            2'd0:    c = 32'd45037112;
            2'd1:    c = 32'd237575834;
            2'd2:    c = 32'd1031834945;
            default: c = 32'd2977042554;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] exp_scale(input logic [1:0] k);
        logic [31:0] s;
        case (k)
            2'd0:    s = 32'd2147483648;
            2'd1:    s = 32'd2553802834;
            2'd2:    s = 32'd3037000500;
            default: s = 32'd3611622603;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/ddt_div.sv */
// Clip check and pipelined restoring divider, one quotient bit per stage.
// Depends on ddt_pkg.
module ddt_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [31:0]              tau,
    input  ddt_pkg::ddt_side_t       side_in,
    input  logic [47:0]              mag,
    output ddt_pkg::ddt_side_t       side_out,
    output logic [ddt_pkg::QBITS-1:0] quot
);

    localparam int N = ddt_pkg::QBITS;

    logic [61:0] clip_lim_reg;

    logic               valid_reg [0:N];
    logic               neg_reg   [0:N];
    logic               clip_reg  [0:N];
    logic [31:0]        rem_reg   [0:N];
    logic [N-1:0]       q_reg     [0:N];

    logic [32:0]        trial    [0:N-1];
    logic               take     [0:N-1];

    // Registered clip limit; user changes the divisor only while idle, unenforced.
    always_ff @(posedge clk)
    begin
        clip_lim_reg <= ddt_pkg::DRIFT_CLIP * tau;
    end

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            trial[k] = {rem_reg[k], 1'b0};
            take[k]  = (trial[k] >= {1'b0, tau});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= side_in.valid;
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    // The dividend is the magnitude shifted up by 32, so only zeros are brought down.
    always_ff @(posedge clk)
    begin
        neg_reg[0]      <= side_in.neg;
        clip_reg[0]     <= (|mag[47:30]) || ({mag[29:0], 32'd0} >= clip_lim_reg);
        rem_reg[0]      <= {mag[29:0], 2'b00};
        q_reg[0]        <= '0;
        for (int k = 0; k < N; k++)
        begin
            neg_reg[k+1]      <= neg_reg[k];
            clip_reg[k+1]     <= clip_reg[k];
            rem_reg[k+1]      <= take[k] ? 32'(trial[k] - {1'b0, tau}) : trial[k][31:0];
            q_reg[k+1]        <= {q_reg[k][N-2:0], take[k]};
        end
    end

    assign side_out.valid = valid_reg[N];
    assign side_out.neg   = neg_reg[N];
    assign quot           = clip_reg[N] ? ddt_pkg::DRIFT_CLIP : q_reg[N];

endmodule

/* hw/rtl/ddt_exp2.sv */
// Pipelined fixed-point exp2 fraction: four polynomial stages and one scale stage.
// Depends on ddt_pkg.
module ddt_exp2 (
    input  logic               clk,
    input  logic               rst_n,
    input  ddt_pkg::ddt_side_t side_in,
    input  logic [31:0]        u,
    output ddt_pkg::ddt_side_t side_out,
    output logic [31:0]        e
);

    logic               valid_reg [0:4];
    logic               neg_reg   [0:4];
    logic [31:0]        u_reg    [0:3];
    logic [31:0]        p_reg    [0:3];
    logic [31:0]        e_reg;

    logic [31:0]        p_in     [0:3];
    logic [29:0]        x_in     [0:3];
    logic [62:0]        prod     [0:3];
    logic [64:0]        scaled;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            p_in[k] = (k == 0) ? 32'd0 : p_reg[(k == 0) ? 0 : k - 1];
            x_in[k] = (k == 0) ? u[29:0] : u_reg[(k == 0) ? 0 : k - 1][29:0];
            prod[k] = ({1'b0, p_in[k]} + {1'b0, ddt_pkg::poly_coef(2'(k))}) * x_in[k];
        end
        // p is below 2^32, so setting bit 32 adds one.
        scaled = {1'b1, p_reg[3]} * ddt_pkg::exp_scale(u_reg[3][31:30]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= 4; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= side_in.valid;
            for (int k = 0; k < 4; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0]      <= side_in.neg;
        u_reg[0]        <= u;
        for (int k = 0; k < 4; k++)
        begin
            neg_reg[k+1]      <= neg_reg[k];
            p_reg[k]          <= {1'b0, prod[k][62:32]};
        end
        for (int k = 1; k < 4; k++)
        begin
            u_reg[k] <= u_reg[k-1];
        end
        e_reg <= scaled[62:31];
    end

    assign side_out.valid = valid_reg[4];
    assign side_out.neg   = neg_reg[4];
    assign e              = e_reg;

endmodule

/* hw/rtl/drift_corrected_block_time.sv */
// Top level of the drift-corrected block time pipeline.
// Depends on ddt_pkg, ddt_div and ddt_exp2.
//
// Usage:
//   An item (tip_height, tip_time) is taken at a rising edge with start high
//   and busy low. busy stays low: the pipeline takes one item every cycle.
//   Each item gives one target_time, shown for exactly one cycle with done
//   high, in order. On its way the item passes the 30 divider stages (one
//   quotient bit each), the four polynomial multipliers and the scale and
//   spacing multipliers.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Index 0 is block_spacing, 1 drift_timespan,
//   2 genesis_time; index 3 is ignored. Write only while the pipeline is empty.
//   Reset clears all valid bits and loads the default register values.
//   The receiver cannot stall; every result must be taken when done is high.
module drift_corrected_block_time (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] tip_height,
    input  logic [31:0] tip_time,
    output logic        done,
    output logic [16:0] target_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] spacing_reg;
    logic [31:0] timespan_reg;
    logic [31:0] genesis_reg;
    logic [31:0] tau;

    logic        v1_reg, v2_reg, v3_reg;
    logic [46:0] prod_reg;
    logic [31:0] tip1_reg, tip2_reg;
    logic [47:0] expected_reg;
    logic        neg3_reg;
    logic [47:0] mag3_reg;

    ddt_pkg::ddt_side_t side3, div_side, u_side, exp_side;
    logic [ddt_pkg::QBITS-1:0] quot;

    logic        neg_q;
    logic        v35_reg, neg35_reg;
    logic [31:0] u35_reg;
    logic [31:0] e;

    logic        v41_reg, neg41_reg;
    logic [15:0] hi41_reg;
    logic [47:0] se;
    logic [16:0] sum;

    logic        v42_reg;
    logic [16:0] out42_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign tau       = (timespan_reg == 32'd0) ? 32'd1 : timespan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg  <= 16'd600;
            timespan_reg <= 32'd1209600;
            genesis_reg  <= 32'd1231006505;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ddt_pkg::REG_BLOCK_SPACING:  spacing_reg  <= cfg_data[15:0];
                ddt_pkg::REG_DRIFT_TIMESPAN: timespan_reg <= cfg_data;
                ddt_pkg::REG_GENESIS_TIME:   genesis_reg  <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v35_reg <= 1'b0;
            v41_reg <= 1'b0;
            v42_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= start && !busy;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v35_reg <= div_side.valid;
            v41_reg <= exp_side.valid;
            v42_reg <= v41_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= tip_height * spacing_reg;
        tip1_reg     <= tip_time;
        expected_reg <= {1'b0, prod_reg} + {16'd0, genesis_reg};
        tip2_reg     <= tip1_reg;
        neg3_reg     <= expected_reg < {16'd0, tip2_reg};
        mag3_reg     <= (expected_reg < {16'd0, tip2_reg})
                        ? ({16'd0, tip2_reg} - expected_reg)
                        : (expected_reg - {16'd0, tip2_reg});
    end

    assign side3.valid = v3_reg;
    assign side3.neg   = neg3_reg;

    ddt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .tau      (tau),
        .side_in  (side3),
        .mag      (mag3_reg),
        .side_out (div_side),
        .quot     (quot)
    );

    // A negative drift that truncates to zero is treated as positive.
    assign neg_q = div_side.neg && (quot != '0);

    always_ff @(posedge clk)
    begin
        neg35_reg <= neg_q;
        u35_reg   <= neg_q ? (32'd0 - {2'b00, quot}) : {2'b00, quot};
    end

    assign u_side.valid = v35_reg;
    assign u_side.neg   = neg35_reg;

    ddt_exp2 u_exp2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (u_side),
        .u        (u35_reg),
        .side_out (exp_side),
        .e        (e)
    );

    assign se  = spacing_reg * e;
    assign sum = {1'b0, spacing_reg} + {1'b0, hi41_reg};

    always_ff @(posedge clk)
    begin
        hi41_reg  <= se[47:32];
        neg41_reg <= exp_side.neg;
        out42_reg <= neg41_reg ? {1'b0, sum[16:1]} : sum;
    end

    assign done        = v42_reg;
    assign target_time = out42_reg;

endmodule

/* hw/rtl/ddt_checker.sv */
// Port-level checker for drift_corrected_block_time, attached by bind.
// Depends on ddt_pkg for the pipeline latency.
module ddt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done
);

    // Every accepted transaction produces a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(ddt_pkg::LATENCY) done)
        else $error("accepted transaction produced no result");

    // No result appears without a matching accepted transaction.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ddt_pkg::LATENCY))
        else $error("result without accepted transaction");

    // The pipeline never refuses work.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("pipeline stalled the input");

endmodule

bind drift_corrected_block_time ddt_checker u_ddt_checker (.*);
